>>> sv/cht_pkg.sv
// Shared types and constants for the chained hash table unit.
package cht_pkg;

  localparam int MAX_BUCKETS_DEF = 64;
  localparam int POOL_NODES_DEF  = 256;
  localparam int KEY_BITS_DEF    = 32;
  localparam int DATA_BITS_DEF   = 32;
  localparam int CFG_BITS        = 7;
  localparam int DEFAULT_BUCKETS = 11;
  localparam int OP_BITS         = 2;
  localparam int COUNT_BITS      = 9;
  localparam int OUT_DATA_BITS   = 32;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_HEAD,
    ST_READ,
    ST_CMP,
    ST_ACT,
    ST_ALLOC,
    ST_FREE,
    ST_DONE
  } state_t;

endpackage

>>> sv/cht_if.sv
// Valid/ready channel interfaces for the chained hash table unit.
interface cht_in_if #(
  parameter int KEY_BITS  = cht_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = cht_pkg::DATA_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [cht_pkg::OP_BITS-1:0] op;
  logic [KEY_BITS-1:0]        key;
  logic [DATA_BITS-1:0]       data;
  modport source (output valid, op, key, data, input ready);
  modport sink   (input valid, op, key, data, output ready);
endinterface

interface cht_out_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [cht_pkg::OUT_DATA_BITS-1:0] data_out;
  logic                           full_res;
  logic [cht_pkg::COUNT_BITS-1:0] entry_count;
  modport source (output valid, found, data_out, full_res, entry_count, input ready);
  modport sink   (input valid, found, data_out, full_res, entry_count, output ready);
endinterface

>>> sv/cht_front.sv
// Front end: accepts commands into a short queue.
module cht_front #(
  parameter int KEY_BITS  = cht_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = cht_pkg::DATA_BITS_DEF,
  parameter int W         = cht_pkg::OP_BITS + KEY_BITS + DATA_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_item,
  output logic         q_valid,
  input  logic         q_pop,
  output logic [W-1:0] q_item
);
  logic [W-1:0] slots [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   fill;
  logic         push;

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_item;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop && q_valid) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end
endmodule

>>> sv/cht_back.sv
// Back end: bucket selection, chain walk, node pool and table updates.
module cht_back #(
  parameter int MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF,
  parameter int POOL_NODES  = cht_pkg::POOL_NODES_DEF,
  parameter int KEY_BITS    = cht_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS   = cht_pkg::DATA_BITS_DEF,
  parameter int W           = cht_pkg::OP_BITS + KEY_BITS + DATA_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [cht_pkg::CFG_BITS-1:0]      bucket_count,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  logic [W-1:0]                      q_item,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic                              res_found,
  output logic [cht_pkg::OUT_DATA_BITS-1:0] res_data,
  output logic                              res_full,
  output logic [cht_pkg::COUNT_BITS-1:0]    res_count
);
  localparam int NB  = $clog2(POOL_NODES + 1);
  localparam int AB  = $clog2(POOL_NODES);
  localparam int BB  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CB  = $clog2(POOL_NODES + 1);
  localparam int MB  = $clog2(MAX_BUCKETS + 1);
  localparam int DW  = KEY_BITS + MB - 1;
  localparam logic [NB-1:0] NIL = NB'(POOL_NODES);

  logic [KEY_BITS-1:0]  node_keys  [POOL_NODES];
  logic [DATA_BITS-1:0] node_vals  [POOL_NODES];
  logic [NB-1:0]        node_links [POOL_NODES];
  logic [NB-1:0]        heads      [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] head_used;

  cht_pkg::state_t state, state_next;
  cht_pkg::op_t    op;
  logic [KEY_BITS-1:0]  key;
  logic [DATA_BITS-1:0] data;
  logic [KEY_BITS-1:0]  rem;
  logic [DW-1:0]        dsh;
  logic [MB-1:0]        nbk;
  logic [BB-1:0]        bucket;
  logic [NB-1:0]        cur, prev, free_head;
  logic [CB-1:0]        fresh, count;
  logic [KEY_BITS-1:0]  rd_key;
  logic [DATA_BITS-1:0] rd_val;
  logic [NB-1:0]        rd_link;
  logic [15:0]          steps;
  logic                 found, full;
  logic [DATA_BITS-1:0] dout;

  // Active bucket count, clamped.
  always_comb begin
    if (bucket_count == '0) begin
      nbk = MB'(1);
    end else if (32'(bucket_count) > MAX_BUCKETS) begin
      nbk = MB'(MAX_BUCKETS);
    end else begin
      nbk = MB'(bucket_count);
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      cht_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = cht_pkg::ST_MOD;
        end
      end
      cht_pkg::ST_MOD: begin
        if (steps == 16'(KEY_BITS - 1)) begin
          state_next = cht_pkg::ST_HEAD;
        end
      end
      cht_pkg::ST_HEAD: begin
        state_next = (op == cht_pkg::OP_NONE) ? cht_pkg::ST_DONE : cht_pkg::ST_READ;
      end
      cht_pkg::ST_READ: begin
        state_next = (cur == NIL) ? cht_pkg::ST_ACT : cht_pkg::ST_CMP;
      end
      cht_pkg::ST_CMP: begin
        state_next = cht_pkg::ST_READ;
        if (rd_key == key || 32'(steps) > POOL_NODES) begin
          state_next = cht_pkg::ST_ACT;
        end
      end
      cht_pkg::ST_ACT: begin
        state_next = cht_pkg::ST_DONE;
        if (op == cht_pkg::OP_INSERT && cur == NIL && free_head != NIL) begin
          state_next = cht_pkg::ST_ALLOC;
        end
      end
      cht_pkg::ST_ALLOC: state_next = cht_pkg::ST_FREE;
      cht_pkg::ST_FREE: state_next = cht_pkg::ST_DONE;
      cht_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = cht_pkg::ST_IDLE;
        end
      end
      default: state_next = cht_pkg::ST_IDLE;
    endcase
  end

  assign res_valid = (state == cht_pkg::ST_DONE);
  assign res_found = found;
  assign res_data  = cht_pkg::OUT_DATA_BITS'(dout);
  assign res_full  = full;
  assign res_count = cht_pkg::COUNT_BITS'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cht_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Node memory reads are registered.
  always_ff @(posedge clk) begin
    rd_key  <= node_keys[cur[AB-1:0]];
    rd_val  <= node_vals[cur[AB-1:0]];
    rd_link <= node_links[cur[AB-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_used <= '0;
      free_head <= NIL;
      fresh     <= '0;
      count     <= '0;
    end else begin
      case (state)
        cht_pkg::ST_IDLE: begin
          if (q_valid) begin
            op    <= cht_pkg::op_t'(q_item[W-1 -: cht_pkg::OP_BITS]);
            key   <= q_item[KEY_BITS+DATA_BITS-1 -: KEY_BITS];
            data  <= q_item[DATA_BITS-1:0];
            rem   <= q_item[KEY_BITS+DATA_BITS-1 -: KEY_BITS];
            dsh   <= DW'(nbk) << (KEY_BITS - 1);
            found <= 1'b0;
            full  <= 1'b0;
            dout  <= '0;
            steps <= '0;
            prev  <= NIL;
          end
        end
        cht_pkg::ST_MOD: begin
          // Restoring remainder, one shifted divisor per cycle.
          if (DW'(rem) >= dsh) begin
            rem <= rem - KEY_BITS'(dsh);
          end
          dsh   <= dsh >> 1;
          steps <= steps + 16'd1;
        end
        cht_pkg::ST_HEAD: begin
          bucket <= BB'(rem);
          cur    <= head_used[BB'(rem)] ? heads[BB'(rem)] : NIL;
          steps  <= '0;
        end
        cht_pkg::ST_READ: ;
        cht_pkg::ST_CMP: begin
          if (rd_key != key && 32'(steps) <= POOL_NODES) begin
            prev  <= cur;
            cur   <= rd_link;
            steps <= steps + 16'd1;
          end else if (rd_key != key) begin
            cur <= NIL;
          end
        end
        cht_pkg::ST_ACT: begin
          found <= (cur != NIL);
          case (op)
            cht_pkg::OP_INSERT: begin
              if (cur != NIL) begin
                node_vals[cur[AB-1:0]] <= data;
              end else if (free_head != NIL) begin
                cur <= free_head;
              end else if (32'(fresh) < POOL_NODES) begin
                node_keys[fresh[AB-1:0]]  <= key;
                node_vals[fresh[AB-1:0]]  <= data;
                node_links[fresh[AB-1:0]] <= NIL;
                if (prev != NIL) begin
                  node_links[prev[AB-1:0]] <= NB'(fresh);
                end else begin
                  heads[bucket]     <= NB'(fresh);
                  head_used[bucket] <= 1'b1;
                end
                fresh <= fresh + CB'(1);
                count <= count + CB'(1);
              end else begin
                full <= 1'b1;
              end
            end
            cht_pkg::OP_REMOVE: begin
              if (cur != NIL) begin
                if (prev != NIL) begin
                  node_links[prev[AB-1:0]] <= rd_link;
                end else begin
                  heads[bucket]     <= rd_link;
                  head_used[bucket] <= 1'b1;
                end
                node_links[cur[AB-1:0]] <= free_head;
                free_head <= cur;
                if (count != '0) begin
                  count <= count - CB'(1);
                end
              end
            end
            cht_pkg::OP_LOOKUP: begin
              if (cur != NIL) begin
                dout <= rd_val;
              end
            end
            default: ;
          endcase
        end
        cht_pkg::ST_ALLOC: ;
        cht_pkg::ST_FREE: begin
          // cur holds the free-list head; rd_link is its successor.
          free_head <= rd_link;
          node_keys[cur[AB-1:0]]  <= key;
          node_vals[cur[AB-1:0]]  <= data;
          node_links[cur[AB-1:0]] <= NIL;
          if (prev != NIL) begin
            node_links[prev[AB-1:0]] <= cur;
          end else begin
            heads[bucket]     <= cur;
            head_used[bucket] <= 1'b1;
          end
          count <= count + CB'(1);
        end
        default: ;
      endcase
    end
  end
endmodule

>>> sv/chained_hash_table_unit.sv
// Top level of the chained hash table unit.
// Each command beat (insert, remove, lookup or no-op) yields exactly one
// result beat, in order. A two-entry queue takes commands while the back end
// works. The back end handles one command at a time: it takes the command,
// works out the bucket remainder (one restoring step per key bit) and reads
// the bucket head; a no-op then goes straight to its result. Other commands
// walk the chain, each node read from the registered node memory and then
// compared, with a final read when the key is absent, then update the table,
// with an allocate and a free-list step when an insert reuses a freed node,
// and present the result until it is taken. bucket_count must be written only
// while the block is idle; the block itself does not enforce it. Bucket heads
// carry one valid bit each, so no clearing pass is needed after reset.
module chained_hash_table_unit #(
  parameter int MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF,
  parameter int POOL_NODES  = cht_pkg::POOL_NODES_DEF,
  parameter int KEY_BITS    = cht_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS   = cht_pkg::DATA_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cht_pkg::CFG_BITS-1:0] cfg_wdata,
  cht_in_if.sink                       in_ch,
  cht_out_if.source                    out_ch
);
  localparam int W = cht_pkg::OP_BITS + KEY_BITS + DATA_BITS;

  logic [cht_pkg::CFG_BITS-1:0] bucket_count;
  logic         q_valid;
  logic         q_pop;
  logic [W-1:0] q_item;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= cht_pkg::CFG_BITS'(cht_pkg::DEFAULT_BUCKETS);
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  cht_front #(.KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS), .W(W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  ({in_ch.op, in_ch.key, in_ch.data}),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  cht_back #(
    .MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES),
    .KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS), .W(W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .bucket_count (bucket_count),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .res_valid    (out_ch.valid),
    .res_ready    (out_ch.ready),
    .res_found    (out_ch.found),
    .res_data     (out_ch.data_out),
    .res_full     (out_ch.full_res),
    .res_count    (out_ch.entry_count)
  );
endmodule

>>> sv/cht_checker.sv
// Port-level checks for the chained hash table unit, bound to the top level.
module cht_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       found,
  input logic       full_res,
  input logic [8:0] entry_count
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry_count))
    else $error("result dropped while stalled");
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && full_res |-> !found)
    else $error("full with key present");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= 9'd256)
    else $error("count out of range");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind chained_hash_table_unit cht_checker u_cht_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .found       (out_ch.found),
  .full_res    (out_ch.full_res),
  .entry_count (out_ch.entry_count)
);

>>> tb/cht_tb_if.sv
// Result beat type used by the testbench scoreboard.
`timescale 1ns / 1ps
package cht_tb_pkg;

  typedef struct packed {
    logic        found;
    logic [31:0] data_out;
    logic        full_res;
    logic [8:0]  entry_count;
  } lookup_result_t;
endpackage

>>> tb/tb_chained_hash_table_unit.sv
// Self-checking testbench for the chained hash table unit.
`timescale 1ns / 1ps
module tb_chained_hash_table_unit;

  localparam int NIL = cht_pkg::POOL_NODES_DEF;

  // The scoreboard mirrors the table: bucket heads, node arrays, free list and
  // the count of stored entries. Every accepted command beat is applied to this
  // shadow table at once, and its result is queued for the output checker.
  class hash_table_scoreboard;
    int unsigned    buckets;
    int unsigned    heads[cht_pkg::MAX_BUCKETS_DEF];
    logic [31:0]    keys[cht_pkg::POOL_NODES_DEF];
    logic [31:0]    values[cht_pkg::POOL_NODES_DEF];
    int unsigned    links[cht_pkg::POOL_NODES_DEF];
    int unsigned    free_head;
    int unsigned    fresh_next;
    int unsigned    stored;
    cht_tb_pkg::lookup_result_t pending[$];
    int             errors;

    function new();
      buckets = cht_pkg::DEFAULT_BUCKETS;
      foreach (heads[i]) heads[i] = NIL;
      free_head = NIL;
      fresh_next = 0;
      stored = 0;
      errors = 0;
    endfunction

    function void set_buckets(logic [6:0] v);
      buckets = v;
    endfunction

    // Apply one accepted command beat to the shadow table.
    function void note_command(cht_pkg::op_t op, logic [31:0] key, logic [31:0] data);
      cht_tb_pkg::lookup_result_t r;
      int unsigned nb, bkt, cur, prv, n;
      r = '0;
      if (op != cht_pkg::OP_NONE) begin
        // A zero count acts as one bucket; larger ones saturate at the maximum.
        nb = (buckets == 0) ? 1 :
             (buckets > cht_pkg::MAX_BUCKETS_DEF ? cht_pkg::MAX_BUCKETS_DEF : buckets);
        bkt = key % nb;
        cur = heads[bkt];
        prv = NIL;
        while (cur != NIL && keys[cur] != key) begin
          prv = cur;
          cur = links[cur];
        end
        r.found = (cur != NIL);
        case (op)
          cht_pkg::OP_INSERT: begin
            if (cur != NIL) begin
              values[cur] = data;
            end else begin
              n = NIL;
              if (free_head != NIL) begin
                n = free_head;
                free_head = links[n];
              end else if (fresh_next < cht_pkg::POOL_NODES_DEF) begin
                n = fresh_next;
                fresh_next++;
              end
              if (n != NIL) begin
                keys[n] = key;
                values[n] = data;
                links[n] = NIL;
                if (prv != NIL) links[prv] = n;
                else heads[bkt] = n;
                stored++;
              end else begin
                r.full_res = 1'b1;
              end
            end
          end
          cht_pkg::OP_REMOVE: begin
            if (cur != NIL) begin
              if (prv != NIL) links[prv] = links[cur];
              else heads[bkt] = links[cur];
              links[cur] = free_head;
              free_head = cur;
              stored--;
            end
          end
          default: begin
            if (cur != NIL) r.data_out = values[cur];
          end
        endcase
      end
      r.entry_count = stored[8:0];
      pending.push_back(r);
    endfunction

    function void check_result(cht_tb_pkg::lookup_result_t got);
      cht_tb_pkg::lookup_result_t exp;
      if (pending.size() == 0) begin
        $error("result beat with no command waiting");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.found !== exp.found) begin
        $error("found: expected %0d, got %0d", exp.found, got.found);
        errors++;
      end
      if (got.data_out !== exp.data_out) begin
        $error("data_out: expected %h, got %h", exp.data_out, got.data_out);
        errors++;
      end
      if (got.full_res !== exp.full_res) begin
        $error("full_res: expected %0d, got %0d", exp.full_res, got.full_res);
        errors++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  cht_in_if  cmd_ch ();
  cht_out_if res_ch ();

  chained_hash_table_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (cmd_ch.sink),
    .out_ch   (res_ch.source)
  );

  always #5 clk = ~clk;

  hash_table_scoreboard table_sb = new();

  // Keys are drawn mostly from a small pool so that inserts, hits, removes and
  // long chains all happen; a few come from the whole 32-bit range.
  logic [31:0] key_pool[48];
  int          burst_left;
  int          commands_sent;
  int          full_seen;
  int          hits_seen;
  bit          stall_mode;

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.op    = cht_pkg::OP_NONE;
    cmd_ch.key   = '0;
    cmd_ch.data  = '0;
    res_ch.ready = 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
  end

  // The result side stalls on a pattern of its own: long stretches always
  // ready, then stretches that drop ready at random.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
      res_ch.ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // Result beats are sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      table_sb.check_result({res_ch.found, res_ch.data_out, res_ch.full_res,
                             res_ch.entry_count});
      if (res_ch.full_res) full_seen++;
      if (res_ch.found) hits_seen++;
    end
  end

  // Send one command beat. The sender works in bursts; between bursts it
  // drops valid for a random gap so gaps land on every phase of the back end.
  task automatic send_command(cht_pkg::op_t op, logic [31:0] key, logic [31:0] data);
    if (burst_left == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.op    <= op;
    cmd_ch.key   <= key;
    cmd_ch.data  <= data;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    table_sb.note_command(op, key, data);
    commands_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Wait until every expected result has arrived, then let the back end settle.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (table_sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_buckets(logic [6:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    table_sb.set_buckets(v);
  endtask

  // A random phase: mostly commands on the key pool, some wide keys, some
  // no-op beats.
  task automatic random_phase(int count, int pool_used);
    cht_pkg::op_t op;
    logic [31:0]  key;
    int           pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) op = cht_pkg::OP_INSERT;
      else if (pick < 70) op = cht_pkg::OP_REMOVE;
      else if (pick < 96) op = cht_pkg::OP_LOOKUP;
      else op = cht_pkg::OP_NONE;
      key = ($urandom_range(0, 9) == 0) ? $urandom() :
            key_pool[$urandom_range(0, pool_used - 1)];
      send_command(op, key, $urandom());
      // Once in a while the sender waits for the block to go quiet.
      if ($urandom_range(0, 299) == 0) drain();
    end
  endtask

  initial begin
    burst_left = 0;
    commands_sent = 0;
    full_seen = 0;
    hits_seen = 0;
    stall_mode = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extreme keys and data at the reset bucket count, every op,
    // updates, misses on remove and lookup, and the unused op code.
    send_command(cht_pkg::OP_LOOKUP, 32'h0, 32'h0);
    send_command(cht_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_command(cht_pkg::OP_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_command(cht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_command(cht_pkg::OP_INSERT, 32'd11, 32'hA5A5_5A5A);
    send_command(cht_pkg::OP_INSERT, 32'd22, 32'h5A5A_A5A5);
    send_command(cht_pkg::OP_LOOKUP, 32'd11, 32'h0);
    send_command(cht_pkg::OP_LOOKUP, 32'd22, 32'h0);
    send_command(cht_pkg::OP_INSERT, 32'd11, 32'h1234_5678);
    send_command(cht_pkg::OP_LOOKUP, 32'd11, 32'h0);
    send_command(cht_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(cht_pkg::OP_REMOVE, 32'h0, 32'h0);
    send_command(cht_pkg::OP_REMOVE, 32'd11, 32'h0);
    send_command(cht_pkg::OP_LOOKUP, 32'd22, 32'h0);
    send_command(cht_pkg::OP_INSERT, 32'd33, 32'h0000_0001);
    send_command(cht_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    drain();

    // Zero and out-of-range counts: zero acts as one bucket, so every key sits on
    // one chain, and a new modulus also strands earlier entries.
    write_buckets(7'd0);
    random_phase(60, 8);
    drain();
    write_buckets(7'd127);
    random_phase(80, 16);
    drain();

    // Fill the pool: more distinct keys than nodes, so inserts report full
    // and updates of present keys still go through.
    write_buckets(7'd64);
    for (int i = 0; i < 280; i++) send_command(cht_pkg::OP_INSERT, $urandom(), $urandom());
    send_command(cht_pkg::OP_INSERT, 32'h0, 32'hDEAD_BEEF);
    for (int i = 0; i < 40; i++) random_phase(1, 48);
    for (int i = 0; i < 300; i++) send_command(cht_pkg::OP_REMOVE, $urandom(), 32'h0);
    drain();

    write_buckets(7'd1);
    random_phase(300, 12);
    drain();
    write_buckets(7'd11);
    random_phase(500, 48);
    drain();
    write_buckets(7'($urandom_range(2, 63)));
    random_phase(200, 32);
    drain();

    $display("Ran %0d command beats over bucket counts 0, 1, 11, 64, 127 and random.",
             commands_sent);
    $display("Saw %0d hits and %0d pool-full inserts.", hits_seen, full_seen);
    if (table_sb.errors == 0 && table_sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for roughly 1750 commands, with stalls and gaps.
  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
